>>> hdl/psq_pkg.sv
// Shared types and constants for the process state queue manager.
// No dependencies; imported by psq_ctrl, psq_dp and process_state_queue_manager_core.
package psq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int MEM_BITS_DEF    = 16;

  // fixed port widths
  localparam int ACTION_W = 3;
  localparam int PID_W    = 8;
  localparam int NEED_W   = 16;
  localparam int PLACE_W  = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE  = 3'd0,
    ACT_IO_REQ  = 3'd1,
    ACT_IO_FIN  = 3'd2,
    ACT_TIMEOUT = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_PRELOAD = 3'd5
  } action_t;

  typedef enum logic [PLACE_W-1:0] {
    PLACE_READY   = 2'd0,
    PLACE_BLOCKED = 2'd1,
    PLACE_RUNNING = 2'd2
  } place_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_HELD  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture the transaction fields
    logic commit;  // apply the update, present the result
  } psq_cmd_t;

endpackage

>>> hdl/psq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/psq_fifo.sv
// Circular FIFO: head/tail pointers and count around one psq_ram.
// Depends on psq_ram. Head entry is read every cycle; the RAM read data is registered.
module psq_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    head_nxt  = pop  ? wrap_inc(head_r) : head_r;
    tail_nxt  = push ? wrap_inc(tail_r) : tail_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  psq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail_r),
    .wr_data (push_data),
    .rd_addr (head_r),
    .rd_data (head_data)
  );

  assign count = count_r;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

endmodule

>>> hdl/psq_ctrl.sv
// Controller: two-state sequencer that accepts a transaction and commits it.
// Depends on psq_pkg.
module psq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output psq_pkg::psq_cmd_t cmd
);

  import psq_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r == S_EXEC);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.commit = (state_r == S_EXEC);

endmodule

>>> hdl/psq_dp.sv
// Datapath: ready/blocked/waiting FIFOs, running slot, memory accounting,
// budget register and result registers. Depends on psq_pkg and psq_fifo.
module psq_dp #(
  parameter int QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = psq_pkg::ID_BITS_DEF,
  parameter int MEM_BITS    = psq_pkg::MEM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  psq_pkg::psq_cmd_t              cmd,
  input  logic [psq_pkg::ACTION_W-1:0]   in_action,
  input  logic [psq_pkg::PID_W-1:0]      in_process_id,
  input  logic [psq_pkg::NEED_W-1:0]     in_memory_need,
  input  logic [psq_pkg::PLACE_W-1:0]    in_initial_place,
  input  logic                           cfg_we,
  input  logic [psq_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  output logic [psq_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_running_valid,
  output logic [psq_pkg::PID_W-1:0]      out_running_id,
  output logic [psq_pkg::COUNT_W-1:0]    out_ready_count,
  output logic [psq_pkg::COUNT_W-1:0]    out_blocked_count,
  output logic [psq_pkg::COUNT_W-1:0]    out_waiting_count,
  output logic [psq_pkg::NEED_W-1:0]     out_memory_in_use
);

  import psq_pkg::*;

  localparam int EW = ID_BITS + MEM_BITS;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // captured transaction
  action_t             act_r;
  place_t              place_r;
  logic [ID_BITS-1:0]  id_r;
  logic [MEM_BITS-1:0] need_r;
  logic [1:0]          place_raw_r;

  logic [ID_BITS+PID_W-1:0]   id_ext;
  logic [MEM_BITS+NEED_W-1:0] need_ext;
  logic [MEM_BITS+CFG_W-1:0]  cfg_ext;

  logic [MEM_BITS-1:0] total_r;
  logic [MEM_BITS-1:0] sum_r, sum_nxt;
  logic                run_v_r, run_v_nxt;
  logic [EW-1:0]       run_e_r, run_e_nxt;
  status_t             status_r, status_nxt;
  logic                out_valid_r;

  // FIFO hookup
  logic          rdy_push, rdy_pop, blk_push, blk_pop, wt_push, wt_pop;
  logic [EW-1:0] rdy_wdata, blk_wdata;
  logic [EW-1:0] rdy_head, blk_head, wt_head;
  logic [CW-1:0] rdy_cnt, blk_cnt, wt_cnt;
  logic          rdy_full, blk_full, wt_full;
  logic          rdy_empty, blk_empty, wt_empty;

  logic [EW-1:0]       new_e;
  logic [MEM_BITS-1:0] run_mem, wt_mem, rel_sum, add_new;
  logic                fit_new, fit_wt;

  function automatic logic fits(input logic [MEM_BITS-1:0] s,
                                input logic [MEM_BITS-1:0] m,
                                input logic [MEM_BITS-1:0] lim);
    return ({1'b0, s} + {1'b0, m}) <= {1'b0, lim};
  endfunction

  function automatic logic [MEM_BITS-1:0] sat_add(input logic [MEM_BITS-1:0] a,
                                                  input logic [MEM_BITS-1:0] b);
    logic [MEM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MEM_BITS] ? '1 : s[MEM_BITS-1:0];
  endfunction

  assign id_ext   = (ID_BITS + PID_W)'(in_process_id);
  assign need_ext = (MEM_BITS + NEED_W)'(in_memory_need);
  assign cfg_ext  = (MEM_BITS + CFG_W)'(cfg_data);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r       <= action_t'(in_action);
      place_r     <= place_t'(in_initial_place);
      place_raw_r <= in_initial_place;
      id_r        <= id_ext[ID_BITS-1:0];
      need_r      <= need_ext[MEM_BITS-1:0];
    end
  end

  assign new_e   = {id_r, need_r};
  assign run_mem = run_e_r[MEM_BITS-1:0];
  assign wt_mem  = wt_head[MEM_BITS-1:0];
  assign fit_new = fits(sum_r, need_r, total_r);
  assign add_new = sat_add(sum_r, need_r);
  assign rel_sum = (run_mem > sum_r) ? '0 : sum_r - run_mem;
  assign fit_wt  = fits(rel_sum, wt_mem, total_r);

  always_comb begin
    status_nxt = ST_OK;
    run_v_nxt  = run_v_r;
    run_e_nxt  = run_e_r;
    sum_nxt    = sum_r;
    rdy_push   = 1'b0;
    rdy_pop    = 1'b0;
    rdy_wdata  = new_e;
    blk_push   = 1'b0;
    blk_pop    = 1'b0;
    blk_wdata  = new_e;
    wt_push    = 1'b0;
    wt_pop     = 1'b0;
    unique case (act_r)
      ACT_CREATE: begin
        if (fit_new) begin
          if (rdy_full) begin
            status_nxt = ST_FULL;
          end else begin
            rdy_push = 1'b1;
            sum_nxt  = add_new;
          end
        end else if (wt_full) begin
          status_nxt = ST_FULL;
        end else begin
          wt_push    = 1'b1;
          status_nxt = ST_HELD;
        end
      end
      ACT_IO_REQ: begin
        if (!run_v_r) begin
          status_nxt = ST_EMPTY;
        end else if (blk_full) begin
          status_nxt = ST_FULL;
        end else begin
          blk_push  = 1'b1;
          blk_wdata = run_e_r;
          if (rdy_empty) begin
            run_v_nxt = 1'b0;
          end else begin
            rdy_pop   = 1'b1;
            run_e_nxt = rdy_head;
          end
        end
      end
      ACT_IO_FIN: begin
        if (blk_empty) begin
          status_nxt = ST_EMPTY;
        end else if (rdy_full) begin
          status_nxt = ST_FULL;
        end else begin
          blk_pop   = 1'b1;
          rdy_push  = 1'b1;
          rdy_wdata = blk_head;
        end
      end
      ACT_TIMEOUT: begin
        if (!run_v_r) begin
          status_nxt = ST_EMPTY;
        end else if (rdy_full) begin
          status_nxt = ST_FULL;
        end else if (!rdy_empty) begin
          // empty ready queue: the same process simply keeps running
          rdy_push  = 1'b1;
          rdy_wdata = run_e_r;
          rdy_pop   = 1'b1;
          run_e_nxt = rdy_head;
        end
      end
      ACT_RELEASE: begin
        if (!run_v_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          sum_nxt = rel_sum;
          if (rdy_empty) begin
            run_v_nxt = 1'b0;
          end else begin
            rdy_pop   = 1'b1;
            run_e_nxt = rdy_head;
          end
          // ready always has room here: a full queue was just popped
          if (!wt_empty && fit_wt) begin
            wt_pop    = 1'b1;
            rdy_push  = 1'b1;
            rdy_wdata = wt_head;
            sum_nxt   = rel_sum + wt_mem;
          end
        end
      end
      ACT_PRELOAD: begin
        if (place_raw_r == PLACE_READY) begin
          if (rdy_full) begin
            status_nxt = ST_FULL;
          end else begin
            rdy_push = 1'b1;
            sum_nxt  = add_new;
          end
        end else if (place_r == PLACE_BLOCKED) begin
          if (blk_full) begin
            status_nxt = ST_FULL;
          end else begin
            blk_push = 1'b1;
            sum_nxt  = add_new;
          end
        end else if (place_r == PLACE_RUNNING) begin
          if (run_v_r) begin
            status_nxt = ST_FULL;
          end else begin
            run_v_nxt = 1'b1;
            run_e_nxt = new_e;
            sum_nxt   = add_new;
          end
        end else begin
          status_nxt = ST_FULL;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  psq_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ready (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd.commit && rdy_push),
    .push_data (rdy_wdata),
    .pop       (cmd.commit && rdy_pop),
    .head_data (rdy_head),
    .count     (rdy_cnt),
    .full      (rdy_full),
    .empty     (rdy_empty)
  );

  psq_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_blocked (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd.commit && blk_push),
    .push_data (blk_wdata),
    .pop       (cmd.commit && blk_pop),
    .head_data (blk_head),
    .count     (blk_cnt),
    .full      (blk_full),
    .empty     (blk_empty)
  );

  psq_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_waiting (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd.commit && wt_push),
    .push_data (new_e),
    .pop       (cmd.commit && wt_pop),
    .head_data (wt_head),
    .count     (wt_cnt),
    .full      (wt_full),
    .empty     (wt_empty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      sum_r       <= '0;
      run_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_ext[MEM_BITS-1:0];
      end
      if (cmd.commit) begin
        sum_r   <= sum_nxt;
        run_v_r <= run_v_nxt;
      end
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      run_e_r  <= run_e_nxt;
      status_r <= status_nxt;
    end
  end

  // result fields come straight from the state committed on the strobe edge
  logic [ID_BITS+PID_W-1:0]    run_id_ext;
  logic [CW+COUNT_W-1:0]       rdy_cnt_ext, blk_cnt_ext, wt_cnt_ext;
  logic [MEM_BITS+NEED_W-1:0]  sum_ext;

  assign run_id_ext  = (ID_BITS + PID_W)'(run_e_r[EW-1:MEM_BITS]);
  assign rdy_cnt_ext = (CW + COUNT_W)'(rdy_cnt);
  assign blk_cnt_ext = (CW + COUNT_W)'(blk_cnt);
  assign wt_cnt_ext  = (CW + COUNT_W)'(wt_cnt);
  assign sum_ext     = (MEM_BITS + NEED_W)'(sum_r);

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_running_valid = run_v_r;
  assign out_running_id    = run_v_r ? run_id_ext[PID_W-1:0] : '0;
  assign out_ready_count   = rdy_cnt_ext[COUNT_W-1:0];
  assign out_blocked_count = blk_cnt_ext[COUNT_W-1:0];
  assign out_waiting_count = wt_cnt_ext[COUNT_W-1:0];
  assign out_memory_in_use = sum_ext[NEED_W-1:0];

endmodule

>>> hdl/process_state_queue_manager_core.sv
// Process state queue manager: five-state scheduler with memory admission.
// A start is accepted in S_IDLE, where the transaction is loaded; the controller then
// commits it in S_EXEC, and the out_valid strobe is registered from that commit.
// busy is high for the one commit cycle; the next start is taken during the strobe.
// Reset (rst_n low, synchronous): FIFOs empty, running slot empty, memory sum 0,
// budget 0. The result strobe cannot be stalled.
module process_state_queue_manager_core #(
  parameter int QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = psq_pkg::ID_BITS_DEF,
  parameter int MEM_BITS    = psq_pkg::MEM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [psq_pkg::ACTION_W-1:0]   in_action,
  input  logic [psq_pkg::PID_W-1:0]      in_process_id,
  input  logic [psq_pkg::NEED_W-1:0]     in_memory_need,
  input  logic [psq_pkg::PLACE_W-1:0]    in_initial_place,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psq_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  output logic [psq_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_running_valid,
  output logic [psq_pkg::PID_W-1:0]      out_running_id,
  output logic [psq_pkg::COUNT_W-1:0]    out_ready_count,
  output logic [psq_pkg::COUNT_W-1:0]    out_blocked_count,
  output logic [psq_pkg::COUNT_W-1:0]    out_waiting_count,
  output logic [psq_pkg::NEED_W-1:0]     out_memory_in_use
);

  import psq_pkg::*;

  psq_cmd_t cmd;

  assign cfg_ready = 1'b1;

  psq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  psq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .MEM_BITS    (MEM_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_process_id     (in_process_id),
    .in_memory_need    (in_memory_need),
    .in_initial_place  (in_initial_place),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_running_valid (out_running_valid),
    .out_running_id    (out_running_id),
    .out_ready_count   (out_ready_count),
    .out_blocked_count (out_blocked_count),
    .out_waiting_count (out_waiting_count),
    .out_memory_in_use (out_memory_in_use)
  );

endmodule
